/* rtl/core/thermistor_adc_to_temperature_assert.svh */
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_assert
// Assertion helpers for the thermistor converter.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_ASSERT_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_ASSERT_SVH

// Implication checked in the same cycle, held off during reset.
`define THADC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thermistor converter: implication failed");

// Implication checked in the next cycle, held off during reset.
`define THADC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thermistor converter: next-cycle implication failed");

`endif

/* rtl/core/thadc_pkg.sv */
// ----------------------------------------------------------------------------
// thadc_pkg
// Constants and voltage tables for the thermistor ADC to temperature block.
// ----------------------------------------------------------------------------
package thadc_pkg;

  localparam int TABLE_POINTS = 23;
  localparam int VOLT_W       = 11;                        // table points in mV
  localparam int DIFF_W       = 8;                         // largest gap is 114 mV
  localparam int OFF5_W       = DIFF_W + 3;                // 5 * offset
  localparam int TEMP_W       = 7;
  localparam int IDX_W        = $clog2(TABLE_POINTS + 1);  // includes "no hit"
  localparam int PT_W         = $clog2(TABLE_POINTS);
  localparam int Q_W          = 3;                         // step 0..4

  localparam int SCALE_Q13    = 6001;                      // 3000/4095 in Q13
  localparam int SCALE_W      = 13;
  localparam int SCALE_SHIFT  = 13;
  localparam int STEP_DEG     = 5;
  localparam int FIRST_DEG    = -55;

  localparam logic [VOLT_W-1:0] VOLT_TAB [0:1][0:TABLE_POINTS-1] = '{
    '{11'd1291, 11'd1276, 11'd1257, 11'd1233, 11'd1203, 11'd1167, 11'd1123,
      11'd1073, 11'd1016, 11'd952,  11'd884,  11'd813,  11'd741,  11'd668,
      11'd598,  11'd531,  11'd470,  11'd415,  11'd363,  11'd316,  11'd276,
      11'd241,  11'd209},
    '{11'd1810, 11'd1782, 11'd1745, 11'd1698, 11'd1640, 11'd1570, 11'd1488,
      11'd1395, 11'd1293, 11'd1184, 11'd1071, 11'd957,  11'd847,  11'd743,
      11'd647,  11'd559,  11'd482,  11'd413,  11'd354,  11'd303,  11'd259,
      11'd221,  11'd189}
  };

endpackage

/* rtl/core/thermistor_adc_to_temperature.sv */
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature
// NTC thermistor converter: ADC code to whole degrees C by piecewise-linear
// lookup in one of two voltage tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a word (adc_sample_i) is taken at each clock edge where start_i is
//   high and busy_o is low. busy_o stays low: a new word may enter every
//   cycle, so the throughput is one word per cycle.
//   Output: done_o is high for one cycle with temperature_c_o, and results
//   leave in input order, one per word.
//   Pipeline: scale multiply, table compare and priority encode, offset and
//   gap fetch, then a four-way compare that yields the step and the result.
//   These four register stages make up the whole pipeline.
//   Configuration: cfg_we_i writes cfg_wdata_i into the model select; write
//   it only while no word is in flight.
//   Reset: clears the pipeline valid bits and selects the first model.
//   The receiver cannot stall; every result is shown exactly once.
// ----------------------------------------------------------------------------
`include "thermistor_adc_to_temperature_assert.svh"

module thermistor_adc_to_temperature
  import thadc_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [ADC_BITS-1:0]      adc_sample_i,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  output logic                     done_o,
  output logic signed [TEMP_W-1:0] temperature_c_o
);

  localparam int PROD_W = ADC_BITS + SCALE_W;
  localparam int CMP_W  = (ADC_BITS > VOLT_W) ? ADC_BITS : VOLT_W;

  logic sensor_model_q;

  logic                     v1_q, v2_q, v3_q, v4_q;
  logic [ADC_BITS-1:0]      mv1_q, mv1_d, mv2_q;
  logic [IDX_W-1:0]         idx2_q, idx2_d;
  logic [OFF5_W-1:0]        off5_q, off5_d;
  logic [DIFF_W-1:0]        diff_q, diff_d;
  logic                     interp_q, interp_d;
  logic signed [TEMP_W-1:0] base_q, base_d;
  logic signed [TEMP_W-1:0] temp_q, temp_d;

  logic [PROD_W-1:0]        prod;
  logic [TABLE_POINTS-1:0]  ge;
  logic                     at_top, no_hit;
  logic [PT_W-1:0]          pt_idx, prev_idx;
  logic [VOLT_W-1:0]        v_lo, v_hi;
  logic [CMP_W-1:0]         off_full;
  logic [VOLT_W-1:0]        diff_full;
  logic [OFF5_W-1:0]        d1, d2, d3, d4;
  logic [Q_W-1:0]           step;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_model_q <= 1'b0;
    end else if (cfg_we_i) begin
      sensor_model_q <= cfg_wdata_i;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: millivolts = floor(6001 * adc / 8192)
  always_comb begin
    prod  = PROD_W'(adc_sample_i) * PROD_W'(SCALE_Q13);
    mv1_d = prod[PROD_W-1:SCALE_SHIFT];
  end

  // stage 2: first point the voltage is at or above
  always_comb begin
    for (int i = 0; i < TABLE_POINTS; i++) begin
      ge[i] = CMP_W'(mv1_q) >= CMP_W'(VOLT_TAB[sensor_model_q][i]);
    end
    idx2_d = IDX_W'(TABLE_POINTS);
    for (int i = TABLE_POINTS - 1; i >= 0; i--) begin
      if (ge[i]) begin
        idx2_d = IDX_W'(i);
      end
    end
  end

  // stage 3: offset above the point and gap to the previous one
  always_comb begin
    at_top    = (idx2_q == '0);
    no_hit    = (idx2_q == IDX_W'(TABLE_POINTS));
    interp_d  = !at_top && !no_hit;
    pt_idx    = no_hit ? PT_W'(TABLE_POINTS - 1) : idx2_q[PT_W-1:0];
    prev_idx  = at_top ? '0 : pt_idx - PT_W'(1);
    v_lo      = VOLT_TAB[sensor_model_q][pt_idx];
    v_hi      = VOLT_TAB[sensor_model_q][prev_idx];
    off_full  = CMP_W'(mv2_q) - CMP_W'(v_lo);
    diff_full = v_hi - v_lo;
    diff_d    = diff_full[DIFF_W-1:0];
    off5_d    = {1'b0, off_full[DIFF_W-1:0], 2'b00} + OFF5_W'(off_full[DIFF_W-1:0]);
    base_d    = TEMP_W'(FIRST_DEG + STEP_DEG * int'(pt_idx));
  end

  // stage 4: step = floor(5*off / gap), at most four
  always_comb begin
    d1     = OFF5_W'(diff_q);
    d2     = {d1[OFF5_W-2:0], 1'b0};
    d3     = d1 + d2;
    d4     = {d1[OFF5_W-3:0], 2'b00};
    step   = Q_W'(off5_q >= d1) + Q_W'(off5_q >= d2)
           + Q_W'(off5_q >= d3) + Q_W'(off5_q >= d4);
    temp_d = interp_q ? base_q - TEMP_W'(step) : base_q;
  end

  always_ff @(posedge clk_i) begin
    mv1_q    <= mv1_d;
    mv2_q    <= mv1_q;
    idx2_q   <= idx2_d;
    off5_q   <= off5_d;
    diff_q   <= diff_d;
    interp_q <= interp_d;
    base_q   <= base_d;
    temp_q   <= temp_d;
  end

  assign done_o          = v4_q;
  assign temperature_c_o = temp_q;

  `THADC_ASSERT_IMPL(a_latency, clk_i, rst_ni, v1_q, ##3 done_o)
  `THADC_ASSERT_IMPL(a_range, clk_i, rst_ni, done_o,
                     $signed(temperature_c_o) >= -55 && $signed(temperature_c_o) <= 55)
  `THADC_ASSERT_IMPL(a_off_gap, clk_i, rst_ni, v3_q && interp_q,
                     off5_q < (OFF5_W'(diff_q) << 2) + OFF5_W'(diff_q))
  `THADC_ASSERT_NEXT(a_no_extra, clk_i, rst_ni, !v3_q, !done_o)

endmodule
